@@ rtl/core/rdpr_pkg.sv @@
// Shared types, codes and helpers for the remote debug packet receiver.
// Used by rdpr_parse, rdpr_emit and remote_debug_packet_receiver_top; depends on nothing.
package rdpr_pkg;

    // Receive buffer depth that bounds the payload length.
    localparam int BUFFER_DEPTH = 1024;
    localparam int LIMIT_CAP_INT = (BUFFER_DEPTH - 1 < 1023) ? BUFFER_DEPTH - 1 : 1023;
    localparam logic [9:0] LIMIT_CAP = 10'(LIMIT_CAP_INT);
    localparam logic [9:0] MAX_PAYLOAD_RESET = 10'd1023;

    // Framing bytes.
    localparam logic [7:0] CH_START  = 8'h24;
    localparam logic [7:0] CH_END    = 8'h23;
    localparam logic [7:0] CH_ESCAPE = 8'h7d;
    localparam logic [7:0] ESC_XOR   = 8'h20;
    localparam logic [7:0] TX_STX    = 8'h02;
    localparam logic [7:0] TX_G      = 8'h47;
    localparam logic [7:0] TX_ACK    = 8'h2b;
    localparam logic [7:0] TX_NAK    = 8'h2d;
    localparam logic [7:0] TX_EOT    = 8'h04;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_TX      = 3'd1;
    localparam logic [2:0] KIND_GOOD    = 3'd2;
    localparam logic [2:0] KIND_BAD     = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;
    localparam logic [2:0] KIND_OVER    = 3'd5;

    // Burst codes: the group of results that one input byte causes.
    localparam logic [2:0] BURST_NONE     = 3'd0;
    localparam logic [2:0] BURST_PAY      = 3'd1;
    localparam logic [2:0] BURST_PAY_OVER = 3'd2;
    localparam logic [2:0] BURST_OVER     = 3'd3;
    localparam logic [2:0] BURST_RESTART  = 3'd4;
    localparam logic [2:0] BURST_ACK      = 3'd5;

    typedef struct packed {
        logic [2:0] btype;
        logic [7:0] data;
        logic       good;
    } t_burst;

    // Hex digit decode: bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b0, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/rdpr_parse.sv @@
// Input register, framing state machine and configuration register.
// Depends on rdpr_pkg; feeds at most one burst descriptor per byte to rdpr_emit.
module rdpr_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [9:0]         i_cfg_max_payload,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_emit_ready,
    output logic               o_burst_valid,
    output rdpr_pkg::t_burst   o_burst
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_CK1  = 3'd3;
    localparam logic [2:0] PH_CK2  = 3'd4;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [9:0]       r_max_payload;
    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_sum, n_sum;
    logic [9:0]       r_count, n_count;
    logic [3:0]       r_hi, n_hi;
    logic             r_hi_bad, n_hi_bad;
    logic             adv;
    logic [9:0]       lim;
    logic [9:0]       cnt_inc;
    logic             over;
    logic [7:0]       sum_add;
    logic [4:0]       hex;
    rdpr_pkg::t_burst burst;

    assign o_cfg_ready = i_rst_n;
    assign adv         = r_in_valid && i_emit_ready;
    assign o_rx_ready  = i_rst_n && (!r_in_valid || i_emit_ready);

    // Effective limit is the smaller of the register and the buffer cap.
    assign lim     = (r_max_payload < rdpr_pkg::LIMIT_CAP) ? r_max_payload
                                                           : rdpr_pkg::LIMIT_CAP;
    assign cnt_inc = r_count + 10'd1;
    assign over    = cnt_inc >= lim;
    assign sum_add = r_sum + r_in_byte;
    assign hex     = rdpr_pkg::hex_decode(r_in_byte);

    // Next state and the burst that this byte causes.
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_count     = r_count;
        n_hi        = r_hi;
        n_hi_bad    = r_hi_bad;
        burst.btype = rdpr_pkg::BURST_NONE;
        burst.data  = r_in_byte;
        burst.good  = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (r_in_byte == rdpr_pkg::CH_START) begin
                    n_sum   = 8'd0;
                    n_count = 10'd0;
                    if (lim == 10'd0) begin
                        burst.btype = rdpr_pkg::BURST_OVER;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (r_in_byte == rdpr_pkg::CH_START) begin
                    n_sum       = 8'd0;
                    n_count     = 10'd0;
                    burst.btype = rdpr_pkg::BURST_RESTART;
                end else if (r_in_byte == rdpr_pkg::CH_END) begin
                    n_phase = PH_CK1;
                end else if (r_in_byte == rdpr_pkg::CH_ESCAPE) begin
                    n_sum   = sum_add;
                    n_phase = PH_ESC;
                end else begin
                    n_sum   = sum_add;
                    n_count = cnt_inc;
                    if (over) begin
                        burst.btype = rdpr_pkg::BURST_PAY_OVER;
                        n_phase     = PH_HUNT;
                    end else begin
                        burst.btype = rdpr_pkg::BURST_PAY;
                    end
                end
            end
            PH_ESC: begin
                n_sum      = sum_add;
                n_count    = cnt_inc;
                burst.data = r_in_byte ^ rdpr_pkg::ESC_XOR;
                if (over) begin
                    burst.btype = rdpr_pkg::BURST_PAY_OVER;
                    n_phase     = PH_HUNT;
                end else begin
                    burst.btype = rdpr_pkg::BURST_PAY;
                    n_phase     = PH_BODY;
                end
            end
            PH_CK1: begin
                n_hi_bad = hex[4];
                n_hi     = hex[4] ? 4'd0 : hex[3:0];
                n_phase  = PH_CK2;
            end
            PH_CK2: begin
                burst.btype = rdpr_pkg::BURST_ACK;
                burst.good  = !r_hi_bad && !hex[4] && ({r_hi, hex[3:0]} == r_sum);
                n_phase     = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    assign o_burst_valid = adv && (burst.btype != rdpr_pkg::BURST_NONE);
    assign o_burst       = burst;

    // Input register and framing state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_max_payload <= rdpr_pkg::MAX_PAYLOAD_RESET;
            r_phase       <= PH_HUNT;
            r_sum         <= 8'd0;
            r_count       <= 10'd0;
            r_hi          <= 4'd0;
            r_hi_bad      <= 1'b0;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (i_cfg_valid) begin
                r_max_payload <= i_cfg_max_payload;
            end
            if (adv) begin
                r_phase  <= n_phase;
                r_sum    <= n_sum;
                r_count  <= n_count;
                r_hi     <= n_hi;
                r_hi_bad <= n_hi_bad;
            end
        end
    end

    // Received byte; payload only, no reset.
    always_ff @(posedge i_clk) begin
        if (o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

endmodule

@@ rtl/core/rdpr_emit.sv @@
// Result register that holds one burst; sends its results one per cycle when taken.
// Depends on rdpr_pkg; loaded by rdpr_parse.
module rdpr_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_burst_valid,
    input  rdpr_pkg::t_burst i_burst,
    output logic             o_emit_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data,
    output logic             o_last
);

    logic             r_have;
    rdpr_pkg::t_burst r_burst;
    logic [2:0]       r_idx;
    logic [2:0]       final_idx;

    // Index of the last result in the held burst.
    always_comb begin
        case (r_burst.btype)
            rdpr_pkg::BURST_PAY_OVER: final_idx = 3'd1;
            rdpr_pkg::BURST_ACK:      final_idx = 3'd4;
            default:                  final_idx = 3'd0;
        endcase
    end

    assign o_res_valid  = r_have;
    assign o_last       = (r_idx == final_idx);
    assign o_emit_ready = !r_have || (i_res_ready && o_last);

    // Result fields for the current position in the burst.
    always_comb begin
        o_kind = rdpr_pkg::KIND_PAYLOAD;
        o_data = 8'd0;
        case (r_burst.btype)
            rdpr_pkg::BURST_PAY: begin
                o_data = r_burst.data;
            end
            rdpr_pkg::BURST_PAY_OVER: begin
                if (r_idx == 3'd0) begin
                    o_data = r_burst.data;
                end else begin
                    o_kind = rdpr_pkg::KIND_OVER;
                end
            end
            rdpr_pkg::BURST_OVER: begin
                o_kind = rdpr_pkg::KIND_OVER;
            end
            rdpr_pkg::BURST_RESTART: begin
                o_kind = rdpr_pkg::KIND_RESTART;
            end
            rdpr_pkg::BURST_ACK: begin
                o_kind = rdpr_pkg::KIND_TX;
                case (r_idx)
                    3'd0: o_data = rdpr_pkg::TX_STX;
                    3'd1: o_data = rdpr_pkg::TX_G;
                    3'd2: o_data = r_burst.good ? rdpr_pkg::TX_ACK : rdpr_pkg::TX_NAK;
                    3'd3: o_data = rdpr_pkg::TX_EOT;
                    default: begin
                        o_kind = r_burst.good ? rdpr_pkg::KIND_GOOD : rdpr_pkg::KIND_BAD;
                    end
                endcase
            end
            default: begin
                o_kind = rdpr_pkg::KIND_PAYLOAD;
            end
        endcase
    end

    // Burst holding register and position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_emit_ready) begin
            r_have <= i_burst_valid;
            r_idx  <= 3'd0;
        end else if (i_res_ready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_emit_ready && i_burst_valid) begin
            r_burst <= i_burst;
        end
    end

endmodule

@@ rtl/core/remote_debug_packet_receiver_top.sv @@
// Top level of the remote debug packet receiver.
// Depends on rdpr_pkg, rdpr_parse and rdpr_emit.

// Takes one link byte per beat on the rx channel and returns its results on the
// res channel, one result per beat, the final one of each byte marked by o_last.
// A byte passes an input register, the framing logic decides its results
// combinationally, and a result register holds them until they are taken.
// Payload streams at one byte per cycle while results are taken; a byte that
// gives an overflow after its payload has two results, the second checksum digit
// five; new bytes wait while they go out, one result per cycle when taken.
// The user must write the maximum payload length on the cfg channel only while
// the block is idle; the block does not enforce this. It resets to 1023.
module remote_debug_packet_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [9:0] i_cfg_max_payload,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_data,
    output logic       o_last
);

    logic             emit_ready;
    logic             burst_valid;
    rdpr_pkg::t_burst burst;

    // Framing and configuration.
    rdpr_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_max_payload (i_cfg_max_payload),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .i_emit_ready      (emit_ready),
        .o_burst_valid     (burst_valid),
        .o_burst           (burst)
    );

    // Result register and serializer.
    rdpr_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .i_burst       (burst),
        .o_emit_ready  (emit_ready),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_kind        (o_kind),
        .o_data        (o_data),
        .o_last        (o_last)
    );

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // Status results always close the burst of their byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_kind == rdpr_pkg::KIND_GOOD || o_kind == rdpr_pkg::KIND_BAD))
        |-> o_last)
        else $error("packet status not marked last");

    // Results without a byte carry zero data.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind != rdpr_pkg::KIND_PAYLOAD && o_kind != rdpr_pkg::KIND_TX)
        |-> (o_data == 8'd0))
        else $error("status result with nonzero data");

    // The status result follows the end-of-transmission beat right away.
    a_eot_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready && o_kind == rdpr_pkg::KIND_TX
         && o_data == rdpr_pkg::TX_EOT)
        |=> (o_res_valid && (o_kind == rdpr_pkg::KIND_GOOD || o_kind == rdpr_pkg::KIND_BAD)))
        else $error("status missing after acknowledge bytes");

endmodule
